FILE: src/mee_pkg.sv
package mee_pkg;

    // Queue between the classifier and the expander
    localparam int MEE_QUEUE_DEPTH = 4;

    // Characters the escaper looks at
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_QUOT    = 8'h22;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;

    // Longest text of one prefix or one body; a request expands to both
    localparam int TXT_BYTES = 6;
    localparam int TXT_W     = 8 * TXT_BYTES;

    // Text emitted ahead of the body for bytes held back earlier
    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_AMP,
        PFX_AMP_HASH,
        PFX_HEX_OPEN
    } prefix_kind_t;

    // How the current byte itself goes out
    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_RAW,
        BODY_ESC
    } body_kind_t;

    // One classified request, front to back
    typedef struct packed {
        prefix_kind_t pfx;
        body_kind_t   body;
        logic [7:0]   data;
        logic         fin;
    } desc_t;

    // Text with its length; text is right-justified, first byte leftmost
    typedef struct packed {
        logic [TXT_W-1:0] txt;
        logic [2:0]       len;
    } text_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
            d = 8'h30 + {4'd0, nib};
        else
            d = 8'h37 + {4'd0, nib};
        return d;
    endfunction

    // Byte idx of a right-justified text of length len
    function automatic logic [7:0] text_byte(input text_t t, input logic [2:0] idx);
        logic [2:0] k;
        k = t.len - 3'd1 - idx;
        return t.txt[{k, 3'b000} +: 8];
    endfunction

    function automatic text_t prefix_text(input prefix_kind_t p);
        text_t t;
        unique case (p)
            PFX_AMP:      t = '{txt: TXT_W'("&amp;"),  len: 3'd5};
            PFX_AMP_HASH: t = '{txt: TXT_W'("&amp;#"), len: 3'd6};
            PFX_HEX_OPEN: t = '{txt: TXT_W'("&#x"),    len: 3'd3};
            default:      t = '{txt: '0,               len: 3'd0};
        endcase
        return t;
    endfunction

    function automatic text_t body_text(input body_kind_t k, input logic [7:0] b);
        text_t t;
        t = '{txt: TXT_W'(b), len: 3'd1};
        if (k == BODY_NONE)
            t = '{txt: '0, len: 3'd0};
        else if (k == BODY_ESC) begin
            if (b == CH_AMP)
                t = '{txt: TXT_W'("&amp;"), len: 3'd5};
            else if (b == CH_LT)
                t = '{txt: TXT_W'("&lt;"), len: 3'd4};
            else if (b == CH_GT)
                t = '{txt: TXT_W'("&gt;"), len: 3'd4};
            else if (b == CH_QUOT)
                t = '{txt: TXT_W'("&quot;"), len: 3'd6};
            else if (b == CH_APOS)
                t = '{txt: TXT_W'("&apos;"), len: 3'd6};
            else if (b < CTRL_LIMIT)
                t = '{txt: {24'("&#x"), hex_digit(b[7:4]), hex_digit(b[3:0]), CH_SEMI},
                      len: 3'd6};
        end
        return t;
    endfunction

endpackage

FILE: src/mee_front.sv
module mee_front
    import mee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       q_push,
    output desc_t      q_desc
);

    // Lookahead after an ampersand
    typedef enum logic [2:0] {
        LA_NONE     = 3'b001,
        LA_AMP      = 3'b010,
        LA_AMP_HASH = 3'b100
    } la_state_t;

    la_state_t    stage_reg, stage_next;
    logic         pass_reg, pass_next;
    logic         accept;
    prefix_kind_t pfx;
    body_kind_t   body;

    assign accept = push && !full;

    // Classify the request and advance the lookahead state
    always_comb
    begin
        stage_next = stage_reg;
        pass_next  = pass_reg;
        pfx        = PFX_NONE;
        body       = BODY_NONE;
        if (accept)
        begin
            if (pass_reg)
            begin
                // inside &#x...; copy raw; final byte escapes normally
                body      = final_byte ? BODY_ESC : BODY_RAW;
                pass_next = !final_byte && (in_byte != CH_SEMI);
            end
            else
            begin
                unique case (stage_reg)
                    LA_AMP:
                    begin
                        if (in_byte == CH_HASH && !final_byte)
                            stage_next = LA_AMP_HASH;
                        else
                        begin
                            pfx = PFX_AMP;
                            if (in_byte == CH_AMP && !final_byte)
                                stage_next = LA_AMP;
                            else
                            begin
                                stage_next = LA_NONE;
                                body       = BODY_ESC;
                            end
                        end
                    end
                    LA_AMP_HASH:
                    begin
                        if (in_byte == CH_X)
                        begin
                            pfx        = PFX_HEX_OPEN;
                            stage_next = LA_NONE;
                            pass_next  = !final_byte;
                        end
                        else
                        begin
                            pfx = PFX_AMP_HASH;
                            if (in_byte == CH_AMP && !final_byte)
                                stage_next = LA_AMP;
                            else
                            begin
                                stage_next = LA_NONE;
                                body       = BODY_ESC;
                            end
                        end
                    end
                    default:
                    begin
                        if (in_byte == CH_AMP && !final_byte)
                            stage_next = LA_AMP;
                        else
                        begin
                            stage_next = LA_NONE;
                            body       = BODY_ESC;
                        end
                    end
                endcase
            end
            if (final_byte)
            begin
                stage_next = LA_NONE;
                pass_next  = 1'b0;
            end
        end
    end

    // Requests that expand to nothing only update the state
    assign q_push = accept && (pfx != PFX_NONE || body != BODY_NONE);
    assign q_desc = '{pfx: pfx, body: body, data: in_byte, fin: final_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= LA_NONE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            pass_reg  <= pass_next;
        end
    end

    // Pass-through never overlaps a held ampersand
    a_pass_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pass_reg |-> stage_reg == LA_NONE)
        else $error("pass-through with bytes held");

    // A final byte leaves the classifier idle
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_byte |=> stage_reg == LA_NONE && !pass_reg)
        else $error("state left over after final byte");

    // A final byte always yields output
    a_final_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_byte |-> q_push)
        else $error("final byte produced no request");

endmodule

FILE: src/mee_queue.sv
module mee_queue
    import mee_pkg::*;
#(
    parameter int DEPTH = MEE_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    output logic  valid,
    output desc_t head_desc,
    input  logic  pop
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    desc_t            mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CntW'(DEPTH));
    assign valid     = (count_reg != '0);
    assign head_desc = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

FILE: src/mee_back.sv
module mee_back
    import mee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  desc_t      q_desc,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_done
);

    text_t      pfx_txt, body_txt;
    logic [3:0] total;
    logic [3:0] pos_reg, pos_next;
    logic [3:0] body_pos;
    logic       emit_last;
    logic       advance;
    logic [7:0] cur_byte;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       run_last_reg, done_reg;

    // Expansion of the head request
    assign pfx_txt   = prefix_text(q_desc.pfx);
    assign body_txt  = body_text(q_desc.body, q_desc.data);
    assign total     = {1'b0, pfx_txt.len} + {1'b0, body_txt.len};
    assign emit_last = (pos_reg == total - 4'd1);
    assign body_pos  = pos_reg - {1'b0, pfx_txt.len};

    // Byte at the current position: prefix first, then body
    always_comb
    begin
        if (pos_reg < {1'b0, pfx_txt.len})
            cur_byte = text_byte(pfx_txt, pos_reg[2:0]);
        else
            cur_byte = text_byte(body_txt, body_pos[2:0]);
    end

    // Step when the output register is free or being drained
    assign advance = q_valid && (!out_valid_reg || pop);
    assign q_pop   = advance && emit_last;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            pos_next       = emit_last ? 4'd0 : pos_reg + 4'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= cur_byte;
            run_last_reg <= emit_last;
            done_reg     <= emit_last && q_desc.fin;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign string_done = done_reg;

    // Position stays inside the head expansion
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> pos_reg < total)
        else $error("expansion position out of range");

    // Last byte of a request restarts the position
    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> pos_reg == 4'd0)
        else $error("position not cleared after request");

    // End of string only on the last byte of a request
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> run_last_reg)
        else $error("string end without request end");

endmodule

FILE: src/markup_entity_escaper_top.sv
// Channel   Direction  Handshake              Fields
// input     in         push / full            in_byte, final_byte
// result    out        empty / pop            out_byte, run_last, string_done
//
// Up to one byte enters and one escaped byte leaves per cycle.
// A byte expanding to N output bytes (1 to 12) occupies the expander until all N
// have gone out; the descriptor queue (QUEUE_DEPTH entries) lets input continue meanwhile.
// Bytes held for lookahead produce no output.
// rst_n clears the lookahead state, empties the queue and the output register.
// full rises only when the queue is full; a stalled pop holds the output byte.
module markup_entity_escaper_top
    import mee_pkg::*;
#(
    parameter int QUEUE_DEPTH = MEE_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_done
);

    logic  f_push;
    desc_t f_desc;
    logic  q_valid;
    desc_t q_desc;
    logic  q_pop;

    mee_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .q_push     (f_push),
        .q_desc     (f_desc)
    );

    mee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_desc (f_desc),
        .full      (full),
        .valid     (q_valid),
        .head_desc (q_desc),
        .pop       (q_pop)
    );

    mee_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_desc      (q_desc),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule
